// ===== hdl/mmrs_pkg.sv =====
`timescale 1ns / 1ps

package mmrs_pkg;

    // Table geometry.
    localparam int MAP_ENTRIES = 32;
    localparam int ADDR_W      = $clog2(MAP_ENTRIES);
    localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

    // Field widths of the stream payloads.
    localparam int TYPE_W      = 32;
    localparam int ADDRESS_W   = 64;
    localparam int INDEX_W     = 32;
    localparam int MAP_COUNT_W = 6;
    localparam int RSV_W       = 32;
    localparam int ACTION_W    = 2;
    localparam int IN_TDATA_W  = 192;
    localparam int OUT_TDATA_W = 200;

    // Action codes carried on the slave tuser.
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    // Region types.
    localparam logic [TYPE_W-1:0] TYPE_FREE     = 32'h0000_0001;
    localparam logic [TYPE_W-1:0] TYPE_RESERVED = 32'h0000_0002;

    // Configuration register indexes.
    localparam logic CFG_RESERVE_BASE   = 1'b0;
    localparam logic CFG_RESERVE_LENGTH = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0]    etype;
        logic [ADDRESS_W-1:0] base;
        logic [ADDRESS_W-1:0] length;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            entry;
    } t_tbl_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_tbl_rd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_DISPATCH,
        S_SPLIT_LO,
        S_SPLIT_RSV,
        S_SPLIT_HI,
        S_COPY_RSV,
        S_COPY_REG,
        S_QUERY,
        S_RESP
    } t_state;

endpackage

// ===== hdl/memory_map_reserve_and_serve_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// s_axis    in         tvalid/tready              tuser: action; tdata: type, base, length, index
// m_axis    out        tvalid/tready              tuser: carry; tdata: entry, next, count, flag
// cfg       in         i_cfg_wr_en (no wait)      i_cfg_index, i_cfg_wdata
//
// One request is worked on at a time. A clear, an ignored action or an add after an
// overflow goes straight to the response, a query makes one table read first, and an
// add passes through address arithmetic and dispatch, then one step per possible append.
// The single write port of the entry table sets the add rate.
// Reset is synchronous and clears the counters and flags; the entry table is not cleared.
// A finished response sits in the output register, so a stalled master side does not
// keep the next request from being taken once the previous one has been answered.
module memory_map_reserve_and_serve_unit
    import mmrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [RSV_W-1:0]       i_cfg_wdata,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] region_type, [95:32] region_base, [159:96] region_length,
    // [191:160] query_index
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [ACTION_W-1:0]    s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] out_type, [95:32] out_base, [159:96] out_length,
    // [191:160] next_index, [197:192] map_count, [198] overflowed, [199] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] carry
    output logic                   m_axis_tuser
);

    // Configuration registers.
    logic [RSV_W-1:0] r_rsv_base;
    logic [RSV_W-1:0] r_rsv_len;

    // Control state.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_inserted, n_inserted;
    logic             r_failed, n_failed;
    logic             r_out_valid;

    // Captured request.
    logic [ACTION_W-1:0]  r_act;
    logic [TYPE_W-1:0]    r_rtype;
    logic [ADDRESS_W-1:0] r_rbase;
    logic [ADDRESS_W-1:0] r_rlen;
    logic [INDEX_W-1:0]   r_q;

    // Address arithmetic results.
    logic [ADDRESS_W-1:0] r_win_last;
    logic [RSV_W-1:0]     r_win_end;
    logic [ADDRESS_W-1:0] r_reg_end;
    logic                 r_meet;
    logic                 r_below;
    logic                 r_above;
    logic                 r_first;

    // Query results.
    logic                 r_hit;
    logic [INDEX_W-1:0]   r_next;

    // Output register.
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_carry;

    t_tbl_wr tbl_wr;
    t_tbl_rd tbl_rd;
    t_entry  rd_data;

    logic                 accept;
    logic                 out_free;
    logic [RSV_W:0]       win_sum;
    logic [ADDRESS_W-1:0] win_start;
    logic [ADDRESS_W-1:0] reg_last;
    logic [ADDRESS_W-1:0] win_end64;
    logic                 is_free;
    logic                 table_full;
    logic                 copy_full;
    logic [CNT_W:0]       copy_need;
    logic [CNT_W-1:0]     cnt_eff;
    logic [INDEX_W-1:0]   q_plus;
    t_entry               rsv_entry;
    t_entry               resp_entry;
    logic [INDEX_W-1:0]   resp_next;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign win_sum    = {1'b0, r_rsv_base} + {1'b0, r_rsv_len};
    assign win_start  = {{(ADDRESS_W-RSV_W){1'b0}}, r_rsv_base};
    assign win_end64  = {{(ADDRESS_W-RSV_W){1'b0}}, r_win_end};
    assign reg_last   = r_reg_end - 64'd1;
    assign is_free    = (r_rtype == TYPE_FREE);
    assign table_full = (r_count >= CNT_W'(MAP_ENTRIES));
    // The copy path appends one or two entries and checks room for both up front.
    assign copy_need  = {1'b0, r_count} + (r_first ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
    assign copy_full  = (copy_need > (CNT_W+1)'(MAP_ENTRIES));
    // A failed build reads as an empty map.
    assign cnt_eff    = r_failed ? '0 : r_count;
    assign q_plus     = r_q + 32'd1;

    assign rsv_entry.etype  = TYPE_RESERVED;
    assign rsv_entry.base   = win_start;
    assign rsv_entry.length = {{(ADDRESS_W-RSV_W){1'b0}}, r_rsv_len};

    mmrs_table u_table (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (rd_data)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsv_base <= '0;
            r_rsv_len  <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RESERVE_BASE:   r_rsv_base <= i_cfg_wdata;
                CFG_RESERVE_LENGTH: r_rsv_len  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        ACT_ADD:   n_state = r_failed ? S_RESP : S_CALC1;
                        ACT_QUERY: n_state = S_QUERY;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_CALC1:    n_state = S_CALC2;
            S_CALC2:    n_state = S_DISPATCH;
            S_DISPATCH: begin
                if (is_free && r_meet) begin
                    n_state = S_SPLIT_LO;
                end else if (copy_full) begin
                    n_state = S_RESP;
                end else if (r_first) begin
                    n_state = S_COPY_RSV;
                end else begin
                    n_state = S_COPY_REG;
                end
            end
            S_SPLIT_LO:  n_state = (r_below && table_full) ? S_RESP : S_SPLIT_RSV;
            S_SPLIT_RSV: n_state = (!r_inserted && table_full) ? S_RESP : S_SPLIT_HI;
            S_SPLIT_HI:  n_state = S_RESP;
            S_COPY_RSV:  n_state = S_COPY_REG;
            S_COPY_REG:  n_state = S_RESP;
            S_QUERY:     n_state = S_RESP;
            S_RESP:      n_state = out_free ? S_IDLE : S_RESP;
            default:     n_state = S_IDLE;
        endcase
    end

    // Table writes, reads and counter updates.
    always_comb begin
        n_count    = r_count;
        n_inserted = r_inserted;
        n_failed   = r_failed;
        tbl_wr     = '0;
        tbl_rd     = '0;
        tbl_wr.addr = r_count[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept && (s_axis_tuser == ACT_CLEAR)) begin
                    n_count    = '0;
                    n_inserted = 1'b0;
                    n_failed   = 1'b0;
                end
            end
            S_DISPATCH: begin
                if (!(is_free && r_meet) && copy_full) begin
                    n_failed = 1'b1;
                end
            end
            S_SPLIT_LO: begin
                if (r_below) begin
                    if (table_full) begin
                        n_failed = 1'b1;
                    end else begin
                        tbl_wr.en           = 1'b1;
                        tbl_wr.entry.etype  = r_rtype;
                        tbl_wr.entry.base   = r_rbase;
                        tbl_wr.entry.length = win_start - r_rbase;
                        n_count             = r_count + 1'b1;
                    end
                end
            end
            S_SPLIT_RSV: begin
                if (!r_inserted) begin
                    if (table_full) begin
                        n_failed = 1'b1;
                    end else begin
                        tbl_wr.en    = 1'b1;
                        tbl_wr.entry = rsv_entry;
                        n_count      = r_count + 1'b1;
                        n_inserted   = 1'b1;
                    end
                end
            end
            S_SPLIT_HI: begin
                if (r_above) begin
                    if (table_full) begin
                        n_failed = 1'b1;
                    end else begin
                        tbl_wr.en           = 1'b1;
                        tbl_wr.entry.etype  = TYPE_FREE;
                        tbl_wr.entry.base   = win_end64;
                        tbl_wr.entry.length = r_reg_end - win_end64;
                        n_count             = r_count + 1'b1;
                    end
                end
            end
            S_COPY_RSV: begin
                tbl_wr.en    = 1'b1;
                tbl_wr.entry = rsv_entry;
                n_count      = r_count + 1'b1;
                n_inserted   = 1'b1;
            end
            S_COPY_REG: begin
                tbl_wr.en           = 1'b1;
                tbl_wr.entry.etype  = r_rtype;
                tbl_wr.entry.base   = r_rbase;
                tbl_wr.entry.length = r_rlen;
                n_count             = r_count + 1'b1;
            end
            S_QUERY: begin
                tbl_rd.en   = 1'b1;
                tbl_rd.addr = r_q[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_inserted <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_inserted <= n_inserted;
            r_failed   <= n_failed;
        end
    end

    // Request capture and the address arithmetic, one wide operation per stage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= s_axis_tuser;
            r_rtype <= s_axis_tdata[31:0];
            r_rbase <= s_axis_tdata[95:32];
            r_rlen  <= s_axis_tdata[159:96];
            r_q     <= s_axis_tdata[191:160];
        end
        if (r_state == S_CALC1) begin
            // The window's last address does not wrap at 32 bits; its end does.
            r_win_last <= {{(ADDRESS_W-RSV_W-1){1'b0}}, win_sum} - 64'd1;
            r_win_end  <= win_sum[RSV_W-1:0];
            r_reg_end  <= r_rbase + r_rlen;
        end
        if (r_state == S_CALC2) begin
            // The larger start is not above the smaller last address exactly when
            // both starts are at or below both last addresses.
            r_meet  <= (win_start <= r_win_last) && (win_start <= reg_last)
                    && (r_rbase <= r_win_last) && (r_rbase <= reg_last);
            r_below <= (r_rbase < win_start);
            r_above <= (win_end64 < r_reg_end);
            r_first <= !r_inserted && (r_rbase > win_start);
        end
        if (r_state == S_QUERY) begin
            r_hit  <= (r_q < {{(INDEX_W-CNT_W){1'b0}}, cnt_eff});
            r_next <= (q_plus >= {{(INDEX_W-CNT_W){1'b0}}, cnt_eff}) ? '0 : q_plus;
        end
    end

    // Response assembly. Only a query that hits returns table data.
    always_comb begin
        resp_entry = '0;
        resp_next  = '0;
        if ((r_act == ACT_QUERY) && r_hit) begin
            resp_entry = rd_data;
            resp_next  = r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESP) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && out_free) begin
            r_out_carry <= (r_act == ACT_QUERY) && !r_hit;
            r_out_data  <= {1'b0, r_failed, MAP_COUNT_W'(cnt_eff), resp_next,
                            resp_entry.length, resp_entry.base, resp_entry.etype};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_carry;

    // The entry count never goes past the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAP_ENTRIES))
        else $error("entry count above table size");

    // The count only grows through a table write.
    a_count_grows_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > $past(r_count)) |-> $past(tbl_wr.en))
        else $error("entry count grew without a table write");

    // The reserved entry mark is dropped only by a clear request or by reset.
    a_inserted_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_inserted) |->
            (!$past(i_rst_n) || ($past(accept) && ($past(s_axis_tuser) == ACT_CLEAR))))
        else $error("reserved mark dropped without a clear");

    // A failed build reports an empty map.
    a_failed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[198]) |-> (m_axis_tdata[197:192] == '0))
        else $error("failed build reports entries");

endmodule

// ===== hdl/mmrs_table.sv =====
`timescale 1ns / 1ps

// Entry store: one write port, one read port with registered read data.
module mmrs_table
    import mmrs_pkg::*;
(
    input  logic    i_clk,
    input  t_tbl_wr i_wr,
    input  t_tbl_rd i_rd,
    output t_entry  o_rd_data
);

    t_entry r_mem [MAP_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/sv/mmrs_reply_check.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both stream channels of the memory map unit.
// It keeps its own copy of the map table, works out the response to every accepted
// request, and compares each response against the oldest one still outstanding.
module mmrs_reply_check
    import mmrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [RSV_W-1:0]       i_cfg_wdata,

    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [ACTION_W-1:0]    i_s_tuser,

    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tuser,

    output int                     o_failures,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_overflow_hits
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   carry;
        logic [TYPE_W-1:0]      etype;
        logic [ADDRESS_W-1:0]   base;
        logic [ADDRESS_W-1:0]   length;
        logic [INDEX_W-1:0]     next_idx;
        logic [MAP_COUNT_W-1:0] count;
        logic                   overflowed;
    } t_map_reply;

    logic [RSV_W-1:0]     window_base;
    logic [RSV_W-1:0]     window_length;
    logic [TYPE_W-1:0]    map_type   [MAP_ENTRIES];
    logic [ADDRESS_W-1:0] map_base   [MAP_ENTRIES];
    logic [ADDRESS_W-1:0] map_length [MAP_ENTRIES];
    int unsigned          entries_used;
    logic                 window_placed;
    logic                 map_broken;
    t_map_reply           replies_due[$];

    function automatic void store_entry(input logic [TYPE_W-1:0] etype,
                                        input logic [ADDRESS_W-1:0] base,
                                        input logic [ADDRESS_W-1:0] length);
        if (entries_used < MAP_ENTRIES) begin
            map_type[entries_used]   = etype;
            map_base[entries_used]   = base;
            map_length[entries_used] = length;
            entries_used++;
        end
    endfunction

    // A build that runs out of slots is marked broken for good, until a clear.
    function automatic logic reserve_room(input int unsigned need);
        if (entries_used + need > MAP_ENTRIES) begin
            map_broken = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void add_source_region(input logic [TYPE_W-1:0] rtype,
                                              input logic [ADDRESS_W-1:0] rbase,
                                              input logic [ADDRESS_W-1:0] rlen);
        logic [RSV_W-1:0]     win_end32;
        logic [ADDRESS_W-1:0] win_start;
        logic [ADDRESS_W-1:0] win_end;
        logic [ADDRESS_W-1:0] win_last;
        logic [ADDRESS_W-1:0] reg_end;
        logic [ADDRESS_W-1:0] reg_last;
        logic [ADDRESS_W-1:0] lo;
        logic [ADDRESS_W-1:0] hi;
        logic                 lead;

        // The window end wraps at 32 bits, while its last address is taken in 64 bits,
        // so an empty window at address zero reaches the top of the address space.
        win_end32 = window_base + window_length;
        win_start = ADDRESS_W'(window_base);
        win_end   = ADDRESS_W'(win_end32);
        win_last  = win_start + ADDRESS_W'(window_length) - 64'd1;
        reg_end   = rbase + rlen;
        reg_last  = reg_end - 64'd1;
        lo        = (win_start > rbase) ? win_start : rbase;
        hi        = (win_last < reg_last) ? win_last : reg_last;

        if (rtype == TYPE_FREE && lo <= hi) begin
            if (rbase < win_start) begin
                if (!reserve_room(1)) return;
                store_entry(TYPE_FREE, rbase, win_start - rbase);
            end
            if (!window_placed) begin
                if (!reserve_room(1)) return;
                store_entry(TYPE_RESERVED, win_start, ADDRESS_W'(window_length));
                window_placed = 1'b1;
            end
            if (win_end < reg_end) begin
                if (!reserve_room(1)) return;
                store_entry(TYPE_FREE, win_end, reg_end - win_end);
            end
        end else begin
            lead = !window_placed && (rbase > win_start);
            if (!reserve_room(lead ? 2 : 1)) return;
            if (lead) begin
                store_entry(TYPE_RESERVED, win_start, ADDRESS_W'(window_length));
                window_placed = 1'b1;
            end
            store_entry(rtype, rbase, rlen);
        end
    endfunction

    function automatic t_map_reply serve_request(input logic [ACTION_W-1:0] act,
                                                 input logic [IN_TDATA_W-1:0] req);
        t_map_reply         reply;
        logic [INDEX_W-1:0] asked;
        logic [INDEX_W-1:0] after;
        logic [INDEX_W-1:0] live;

        reply = '0;
        case (act)
            ACT_CLEAR: begin
                entries_used  = 0;
                window_placed = 1'b0;
                map_broken    = 1'b0;
            end
            ACT_ADD: begin
                if (!map_broken)
                    add_source_region(req[31:0], req[95:32], req[159:96]);
            end
            ACT_QUERY: begin
                asked = req[191:160];
                live  = map_broken ? '0 : INDEX_W'(entries_used);
                if (asked >= live) begin
                    reply.carry = 1'b1;
                end else begin
                    after          = asked + 1'b1;
                    reply.etype    = map_type[asked];
                    reply.base     = map_base[asked];
                    reply.length   = map_length[asked];
                    reply.next_idx = (after >= live) ? '0 : after;
                end
            end
            default: ;
        endcase
        live             = map_broken ? '0 : INDEX_W'(entries_used);
        reply.count      = live[MAP_COUNT_W-1:0];
        reply.overflowed = map_broken;
        return reply;
    endfunction

    function automatic string describe(input t_map_reply r);
        return $sformatf("carry=%0b type=%h base=%h length=%h next=%0d count=%0d ovf=%0b",
                         r.carry, r.etype, r.base, r.length, r.next_idx, r.count,
                         r.overflowed);
    endfunction

    task automatic note_failure(input string what);
        o_failures++;
        if (o_failures <= REPORT_LIMIT)
            $display("[%0t] response check: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_map_reply want;
        t_map_reply got;

        if (!i_rst_n) begin
            window_base   = '0;
            window_length = '0;
            entries_used  = 0;
            window_placed = 1'b0;
            map_broken    = 1'b0;
            replies_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_RESERVE_BASE)
                    window_base = i_cfg_wdata;
                else
                    window_length = i_cfg_wdata;
            end

            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(serve_request(i_s_tuser, i_s_tdata));

            if (i_m_tvalid && i_m_tready) begin
                got.carry      = i_m_tuser;
                got.etype      = i_m_tdata[31:0];
                got.base       = i_m_tdata[95:32];
                got.length     = i_m_tdata[159:96];
                got.next_idx   = i_m_tdata[191:160];
                got.count      = i_m_tdata[197:192];
                got.overflowed = i_m_tdata[198];
                o_checked++;
                if (replies_due.size() == 0) begin
                    note_failure({"response with no request outstanding: ", describe(got)});
                end else begin
                    want = replies_due.pop_front();
                    if (want.overflowed)
                        o_overflow_hits++;
                    if (got !== want || i_m_tdata[OUT_TDATA_W-1] !== 1'b0)
                        note_failure({"mismatch\n  expected ", describe(want),
                                      "\n  actual   ", describe(got),
                                      $sformatf(" pad=%b", i_m_tdata[OUT_TDATA_W-1])});
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Top of the memory map unit testbench. This module only makes stimulus and gives
// the verdict; the response checker instantiated beside the unit does the prediction
// and the comparison, and hands back how many failures it saw.
module testbench;
    import mmrs_pkg::*;

    // The unit treats the fourth action code as a no-op request.
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    localparam int ITEM_TARGET  = 950;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_index   = CFG_RESERVE_BASE;
    logic [RSV_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACTION_W-1:0]    s_axis_tuser  = ACT_CLEAR;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    int mismatch_total;
    int replies_pending;
    int replies_checked;
    int overflow_replies;

    // Shared pacing controls. When steady_flow is set neither side idles, which
    // gives back-to-back stretches. Each bump of hold_asked makes the receiver
    // hold off for a long stretch so that the unit backs up into its input.
    bit steady_flow = 1'b0;
    int hold_asked  = 0;
    int hold_served = 0;

    // Window currently programmed, used to aim regions at its edges.
    logic [RSV_W-1:0] cur_base = '0;
    logic [RSV_W-1:0] cur_len  = '0;

    int items_sent = 0;
    int sent_by_action [4] = '{0, 0, 0, 0};
    int settings_used = 0;
    int cycles = 0;

    memory_map_reserve_and_serve_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mmrs_reply_check u_reply_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .o_failures      (mismatch_total),
        .o_pending       (replies_pending),
        .o_checked       (replies_checked),
        .o_overflow_hits (overflow_replies)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog. Hitting this limit means the unit has hung somewhere.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Response side. Before each response it draws a random stall, or a long
    // hold-off when one has been asked for, then waits with tready high until a
    // response is taken. Changes happen at the falling edge.
    initial begin : response_sink
        int stall;

        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                stall = HOLD_CYCLES;
                hold_served++;
            end else begin
                stall = steady_flow ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic logic [ADDRESS_W-1:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the falling edge after it was taken.
    // Fields that the action does not use carry random filler, which keeps every
    // bit of the payload moving. tvalid stays high between back-to-back requests.
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [TYPE_W-1:0] rtype,
                                input logic [ADDRESS_W-1:0] rbase,
                                input logic [ADDRESS_W-1:0] rlen,
                                input logic [INDEX_W-1:0] idx);
        int gap;

        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {idx, rlen, rbase, rtype};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        sent_by_action[act]++;
    endtask

    // Stops offering requests and lets every outstanding response come back,
    // so that the unit is idle before a register write.
    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        wait (replies_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_window(input logic [RSV_W-1:0] wbase,
                                  input logic [RSV_W-1:0] wlen);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_RESERVE_BASE;
        i_cfg_wdata <= wbase;
        @(negedge i_clk);
        i_cfg_index <= CFG_RESERVE_LENGTH;
        i_cfg_wdata <= wlen;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_base = wbase;
        cur_len  = wlen;
        settings_used++;
    endtask

    // Adds one source region. Most regions are placed around the current window
    // so that the split, the touching edges and the reserved-first copy all come
    // up often; the rest are fully random.
    task automatic add_random_region();
        logic [TYPE_W-1:0]    rtype;
        logic [ADDRESS_W-1:0] rbase;
        logic [ADDRESS_W-1:0] rlen;
        logic [ADDRESS_W-1:0] wstart;
        logic [ADDRESS_W-1:0] wend;

        wstart = ADDRESS_W'(cur_base);
        wend   = wstart + ADDRESS_W'(cur_len);
        rtype  = TYPE_FREE;
        case ($urandom_range(0, 9))
            0, 1: begin
                // Free memory spanning the window, possibly with nothing left on a side.
                rbase = wstart - $urandom_range(0, 4096);
                rlen  = (wend - rbase) + $urandom_range(0, 8192);
            end
            2: begin
                rbase = wstart + $urandom_range(0, 255);
                rlen  = $urandom_range(1, 256);
            end
            3: begin
                // Free memory ending at, just past or just short of the window start.
                rlen  = $urandom_range(0, 4096);
                rbase = wstart - rlen - $urandom_range(0, 2) + 1;
            end
            4: begin
                rbase = wend + $urandom_range(0, 2) - 1;
                rlen  = $urandom_range(0, 65536);
            end
            5, 6, 7: begin
                // Some other type, above or below the window base.
                rtype = $urandom_range(0, 3);
                if (rtype == TYPE_FREE)
                    rtype = TYPE_RESERVED;
                if ($urandom_range(0, 2) != 0)
                    rbase = wstart + $urandom_range(0, 65536);
                else
                    rbase = wstart - $urandom_range(0, 65536);
                rlen = $urandom_range(0, 65536);
            end
            8: begin
                rtype = $urandom;
                rbase = rand_wide();
                rlen  = rand_wide();
            end
            default: begin
                rbase = rand_wide();
                rlen  = rand_wide() >> $urandom_range(0, 63);
            end
        endcase
        send_request(ACT_ADD, rtype, rbase, rlen, $urandom);
    endtask

    // One build: usually a clear, a run of adds, then a walk through the table
    // by continuation index and a few scattered queries. Some builds are long
    // enough to run out of table room. A little noise is mixed in.
    task automatic run_build();
        int n_adds;
        int walk;

        if ($urandom_range(0, 9) != 0)
            send_request(ACT_CLEAR, $urandom, rand_wide(), rand_wide(), $urandom);
        n_adds = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
        repeat (n_adds) begin
            case ($urandom_range(0, 19))
                0: send_request(ACT_IGNORED, $urandom, rand_wide(), rand_wide(), $urandom);
                1: send_request(ACT_QUERY, $urandom, rand_wide(), rand_wide(),
                                $urandom_range(0, 12));
                default: ;
            endcase
            add_random_region();
        end
        walk = (n_adds + 3 > 34) ? 34 : n_adds + 3;
        for (int i = 0; i < walk; i++)
            send_request(ACT_QUERY, $urandom, rand_wide(), rand_wide(), i);
        repeat (3) begin
            case ($urandom_range(0, 3))
                0: send_request(ACT_QUERY, $urandom, rand_wide(), rand_wide(), '1);
                1: send_request(ACT_QUERY, $urandom, rand_wide(), rand_wide(), $urandom);
                default: send_request(ACT_QUERY, $urandom, rand_wide(), rand_wide(),
                                      $urandom_range(0, MAP_ENTRIES + 2));
            endcase
        end
    endtask

    initial begin : stimulus
        logic [RSV_W-1:0] wbase;
        logic [RSV_W-1:0] wlen;
        int               builds;

        builds = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Out of reset the table is empty and any query runs past it.
        send_request(ACT_QUERY, '0, '0, '0, '0);
        send_request(ACT_IGNORED, '1, '1, '1, '1);
        drain_requests();
        program_window(32'h0009_F000, 32'h0000_1000);

        // A typical map: other type below the window, free memory split around the
        // window, a free region of maximum length and an all-ones entry.
        send_request(ACT_CLEAR, '0, '0, '0, '0);
        send_request(ACT_ADD, TYPE_RESERVED, 64'h0, 64'h9_F000, '0);
        send_request(ACT_ADD, TYPE_FREE, 64'h9_E000, 64'h3000, '0);
        send_request(ACT_ADD, TYPE_FREE, 64'h10_0000, '1, '0);
        send_request(ACT_ADD, '1, '1, '1, '1);
        for (int i = 0; i < 6; i++)
            send_request(ACT_QUERY, '0, '0, '0, i);
        send_request(ACT_QUERY, '0, '0, '0, 6);
        send_request(ACT_QUERY, '0, '0, '0, '1);

        // The reserved entry goes in first ahead of a region above the window; a free
        // region wholly inside the window then adds nothing.
        send_request(ACT_CLEAR, '0, '0, '0, '0);
        send_request(ACT_ADD, 32'h3, 64'h20_0000, 64'h1000, '0);
        send_request(ACT_ADD, TYPE_FREE, 64'h9_F100, 64'h10, '0);
        send_request(ACT_QUERY, '0, '0, '0, 0);
        send_request(ACT_QUERY, '0, '0, '0, 1);
        send_request(ACT_QUERY, '0, '0, '0, 2);

        // A free region equal to the window, then a free region of zero length.
        send_request(ACT_CLEAR, '0, '0, '0, '0);
        send_request(ACT_ADD, TYPE_FREE, 64'h9_F000, 64'h1000, '0);
        send_request(ACT_ADD, TYPE_FREE, 64'h9_F000, 64'h0, '0);
        send_request(ACT_QUERY, '0, '0, '0, 1);

        // Random part. The first builds walk through the extreme window settings.
        while (items_sent < ITEM_TARGET) begin
            if (builds < 8 || $urandom_range(0, 2) == 0) begin
                drain_requests();
                case ((builds < 8) ? builds : $urandom_range(0, 7))
                    0: begin wbase = '0;           wlen = '0;            end
                    1: begin wbase = '1;           wlen = '1;            end
                    2: begin wbase = '0;           wlen = '1;            end
                    3: begin wbase = '1;           wlen = '0;            end
                    4: begin wbase = 32'hFFFF_F000; wlen = 32'h0000_2000; end
                    5: begin wbase = $urandom;      wlen = $urandom;      end
                    6: begin wbase = $urandom;      wlen = $urandom_range(1, 8192); end
                    default: begin
                        wbase = 32'h0009_F000 + ($urandom_range(0, 255) << 12);
                        wlen  = $urandom_range(1, 16) << 12;
                    end
                endcase
                program_window(wbase, wlen);
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            if (builds == 2 || $urandom_range(0, 11) == 0)
                hold_asked++;
            run_build();
            builds++;
        end

        drain_requests();
        $display("Covered %0d requests: %0d clears, %0d adds, %0d queries, %0d no-ops.",
                 items_sent, sent_by_action[ACT_CLEAR], sent_by_action[ACT_ADD],
                 sent_by_action[ACT_QUERY], sent_by_action[ACT_IGNORED]);
        $display("%0d window settings, %0d responses compared, %0d after a table overflow.",
                 settings_used, replies_checked, overflow_replies);
        if (mismatch_total == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
